/* hdl/led_fire_effect_frame_unit_assert.svh */
// Assertion macros shared by the fire effect RTL.
// Included by the files that check their own logic; no other dependencies.
`ifndef LED_FIRE_EFFECT_FRAME_UNIT_ASSERT_SVH
`define LED_FIRE_EFFECT_FRAME_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LFE_ASSERT_ALW(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("lfe: invariant violated");
`define LFE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lfe: same-cycle check failed");
`define LFE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lfe: next-cycle check failed");
`else
`define LFE_ASSERT_ALW(lbl, clk, rstn, cond)
`define LFE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LFE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hdl/lfe_pkg.sv */
// Shared types, constants, microcode program and arithmetic helpers
// for the fire effect frame unit. No dependencies.
package lfe_pkg;

  localparam int PIXEL_COUNT_DEF = 25;
  localparam int SPARK_ZONE_DEF  = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COOLING  = 2'd0,
    REG_SPARKING = 2'd1,
    REG_SEED     = 2'd2
  } reg_idx_e;

  localparam logic [7:0]  COOLING_RST  = 8'd55;
  localparam logic [7:0]  SPARKING_RST = 8'd120;
  localparam logic [15:0] SEED_RST     = 16'd1;
  localparam logic [15:0] LFSR_TAPS    = 16'hB400;

  localparam int          COOL_MULT   = 10;
  localparam logic [7:0]  SPARK_DRAW  = 8'd255;
  localparam logic [7:0]  SPARK_RANGE = 8'd95;
  localparam logic [7:0]  SPARK_BASE  = 8'd160;
  localparam logic [9:0]  DIV3_MUL    = 10'd683;
  localparam int          DIV3_SHIFT  = 11;
  localparam logic [15:0] T192_SCALE  = 16'd191;
  localparam logic [15:0] T192_ROUND  = 16'd127;
  localparam logic [7:0]  PAL_MASK    = 8'h3F;
  localparam logic [7:0]  BAND_HI     = 8'h80;
  localparam logic [7:0]  BAND_MID    = 8'h40;

  // Microcode
  localparam int STEP_W = 4;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_BOUND_A,
    OP_BOUND_B,
    OP_COOL,
    OP_DRIFT,
    OP_DRAW_SPARK,
    OP_TEST,
    OP_DRAW_ZONE,
    OP_DRAW_ADD,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    CND_NEXT,
    CND_NO_TICK,
    CND_NO_SPARK,
    CND_ALWAYS
  } cond_e;

  localparam logic [STEP_W-1:0] ST_WAIT    = 4'd0;
  localparam logic [STEP_W-1:0] ST_BOUND_A = 4'd1;
  localparam logic [STEP_W-1:0] ST_BOUND_B = 4'd2;
  localparam logic [STEP_W-1:0] ST_COOL    = 4'd3;
  localparam logic [STEP_W-1:0] ST_DRIFT   = 4'd4;
  localparam logic [STEP_W-1:0] ST_SPARK   = 4'd5;
  localparam logic [STEP_W-1:0] ST_TEST    = 4'd6;
  localparam logic [STEP_W-1:0] ST_ZONE    = 4'd7;
  localparam logic [STEP_W-1:0] ST_ADD     = 4'd8;
  localparam logic [STEP_W-1:0] ST_EMIT    = 4'd9;

  typedef struct packed {
    op_e               op;
    logic              loop;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_e  op;
    logic adv;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic tick;
    logic out_free;
    logic no_spark;
  } stat_t;

  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    w = '{op: OP_WAIT, loop: 1'b0, cond: CND_NEXT, target: ST_WAIT};
    unique case (step)
      ST_WAIT:    w = '{op: OP_WAIT,       loop: 1'b0, cond: CND_NO_TICK,  target: ST_WAIT};
      ST_BOUND_A: w = '{op: OP_BOUND_A,    loop: 1'b0, cond: CND_NEXT,     target: ST_WAIT};
      ST_BOUND_B: w = '{op: OP_BOUND_B,    loop: 1'b0, cond: CND_NEXT,     target: ST_WAIT};
      ST_COOL:    w = '{op: OP_COOL,       loop: 1'b1, cond: CND_NEXT,     target: ST_WAIT};
      ST_DRIFT:   w = '{op: OP_DRIFT,      loop: 1'b1, cond: CND_NEXT,     target: ST_WAIT};
      ST_SPARK:   w = '{op: OP_DRAW_SPARK, loop: 1'b0, cond: CND_NEXT,     target: ST_WAIT};
      ST_TEST:    w = '{op: OP_TEST,       loop: 1'b0, cond: CND_NO_SPARK, target: ST_EMIT};
      ST_ZONE:    w = '{op: OP_DRAW_ZONE,  loop: 1'b0, cond: CND_NEXT,     target: ST_WAIT};
      ST_ADD:     w = '{op: OP_DRAW_ADD,   loop: 1'b0, cond: CND_NEXT,     target: ST_WAIT};
      ST_EMIT:    w = '{op: OP_EMIT,       loop: 1'b1, cond: CND_ALWAYS,   target: ST_WAIT};
      default:    w = '{op: OP_WAIT,       loop: 1'b0, cond: CND_ALWAYS,   target: ST_WAIT};
    endcase
    return w;
  endfunction

  // Right-shifting Galois step
  function automatic logic [15:0] lfsr_step(logic [15:0] r);
    logic [15:0] n;
    n = r >> 1;
    if (r[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

  // Rounded h*191/255; x/255 done as (x + (x>>8) + 1) >> 8, exact below 2^16
  function automatic logic [7:0] heat_t192(logic [7:0] h);
    logic [15:0] x;
    logic [16:0] s;
    x = ({8'd0, h} * T192_SCALE) + T192_ROUND;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  // Returns {blue, green, red}
  function automatic logic [23:0] heat_palette(logic [7:0] h);
    logic [7:0] t;
    logic [7:0] ramp;
    logic [23:0] c;
    t    = heat_t192(h);
    ramp = {t[5:0] & PAL_MASK[5:0], 2'b00};
    if (t > BAND_HI)       c = {ramp, 8'hFF, 8'hFF};
    else if (t > BAND_MID) c = {8'h00, ramp, 8'hFF};
    else                   c = {8'h00, 8'h00, ramp};
    return c;
  endfunction

endpackage

/* hdl/lfe_useq.sv */
// Microcode sequencer of the fire effect unit: step counter, program ROM,
// pixel loop counter and conditional jumps. Depends on lfe_pkg.
`include "led_fire_effect_frame_unit_assert.svh"

module lfe_useq import lfe_pkg::*; #(
  parameter int PixelCount = PIXEL_COUNT_DEF,
  localparam int CntW = $clog2(PixelCount)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stat_t           stat_i,
  output ctrl_t           ctrl_o,
  output logic [CntW-1:0] cnt_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  uword_t            uw;
  logic              adv;
  logic              take;
  logic              cnt_last;

  assign uw       = ucode(step_q);
  assign cnt_last = (cnt_q == CntW'(PixelCount - 1));

  always_comb begin
    unique case (uw.op)
      OP_WAIT: adv = stat_i.in_valid;
      OP_EMIT: adv = stat_i.out_free;
      default: adv = 1'b1;
    endcase
    unique case (uw.cond)
      CND_NEXT:     take = 1'b0;
      CND_NO_TICK:  take = !stat_i.tick;
      CND_NO_SPARK: take = stat_i.no_spark;
      CND_ALWAYS:   take = 1'b1;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    step_d = step_q;
    cnt_d  = cnt_q;
    if (adv) begin
      if (uw.loop && !cnt_last) begin
        cnt_d = cnt_q + CntW'(1);
      end else begin
        cnt_d  = '0;
        step_d = take ? uw.target : step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_WAIT;
      cnt_q  <= '0;
    end else begin
      step_q <= step_d;
      cnt_q  <= cnt_d;
    end
  end

  assign ctrl_o = '{op: uw.op, adv: adv};
  assign cnt_o  = cnt_q;

  `LFE_ASSERT_ALW(a_step_in_program, clk_i, rst_ni, step_q <= ST_EMIT)
  `LFE_ASSERT_ALW(a_cnt_in_range, clk_i, rst_ni, cnt_q <= CntW'(PixelCount - 1))
  `LFE_ASSERT_IMP(a_cnt_only_in_loops, clk_i, rst_ni, cnt_q != '0, uw.loop)
  `LFE_ASSERT_NXT(a_tick_starts_frame, clk_i, rst_ni, (uw.op == OP_WAIT) && stat_i.in_valid && stat_i.tick, step_q == ST_BOUND_A)

endmodule

/* hdl/led_fire_effect_frame_unit.sv */
// Fire effect frame unit: every accepted input item with tick set advances a
// one-dimensional flame over PixelCount 8-bit heat cells (random cooling,
// upward drift, an occasional spark in the lowest cells) and then sends one
// output item per pixel, pixel 0 first, tlast on the final one, colored by a
// three-band heat palette. An item with tick clear is taken and changes
// nothing. Work is one item at a time under a microcoded sequencer that
// walks the heat cells as a rotating register ring, one cell per cycle:
// one pass each for cooling, drift and color output plus steps for the
// cooling bound, the spark test and the spark draws. Output stalls stretch
// the output pass. Configuration writes are to be taken only while the unit
// is idle; the user must ensure this, as the unit does not enforce it.
// Writing the seed reloads the noise LFSR at once (a zero seed loads 1).
`include "led_fire_effect_frame_unit_assert.svh"

module led_fire_effect_frame_unit import lfe_pkg::*; #(
  parameter int PixelCount = PIXEL_COUNT_DEF,
  parameter int SparkZone  = SPARK_ZONE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,   // [0] tick, [7:1] zero
  // output stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [31:0]           m_axis_tdata_o,   // [4:0] pixel_index, [12:5] red,
                                                  // [20:13] green, [28:21] blue, [31:29] zero
  output logic                  m_axis_tlast_o,   // last_pixel
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CntW     = $clog2(PixelCount);
  localparam int ZoneSize = (SparkZone < PixelCount) ? SparkZone : PixelCount;
  localparam int BoundMax = (255 * COOL_MULT) / PixelCount + 2;
  localparam int BoundW   = $clog2(BoundMax + 1);
  localparam int DrawW    = (BoundW > 8) ? BoundW : 8;
  localparam int Recip    = 65536 / PixelCount;

  ctrl_t           ctrl;
  stat_t           stat;
  logic [CntW-1:0] cnt;

  logic [7:0]  cooling_q;
  logic [7:0]  sparking_q;
  logic [15:0] lfsr_q;

  logic [7:0]  heat_q [PixelCount];
  logic [7:0]  hist1_q, hist2_q;
  logic [27:0] prod_q;
  logic [BoundW-1:0] bound_q;
  logic [7:0]  rnd_q;
  logic [CntW-1:0] zone_y_q;
  logic [7:0]  add_q;
  logic        spark_q;

  logic        out_valid_q;
  logic [4:0]  out_pix_q;
  logic [23:0] out_bgr_q;
  logic        out_last_q;

  logic              tick;
  logic              frame_start;
  logic              is_draw;
  logic [DrawW-1:0]  draw_n;
  logic [15:0]       lfsr_nx;
  logic [DrawW+15:0] draw_prod;
  logic [DrawW-1:0]  draw;
  logic [11:0]       cool_x;
  logic [11:0]       quot0;
  logic [11:0]       rem0;
  logic [11:0]       quot;
  logic [9:0]        drift_sum;
  logic [19:0]       drift_prod;
  logic [7:0]        head;
  logic [7:0]        head_new;
  logic [7:0]        spark_heat;
  logic              rotate;
  logic              emit;

  assign tick        = s_axis_tdata_i[0];
  assign frame_start = (ctrl.op == OP_WAIT) && ctrl.adv && tick;

  assign stat = '{in_valid: s_axis_tvalid_i,
                  tick:     tick,
                  out_free: !out_valid_q || m_axis_tready_i,
                  no_spark: rnd_q >= sparking_q};

  lfe_useq #(
    .PixelCount(PixelCount)
  ) u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .cnt_o  (cnt)
  );

  // Shared draw unit: advance LFSR, scale by multiply-high
  always_comb begin
    is_draw = 1'b1;
    draw_n  = '0;
    unique case (ctrl.op)
      OP_COOL:       draw_n = DrawW'(bound_q);
      OP_DRAW_SPARK: draw_n = DrawW'(SPARK_DRAW);
      OP_DRAW_ZONE:  draw_n = DrawW'(ZoneSize);
      OP_DRAW_ADD:   draw_n = DrawW'(SPARK_RANGE);
      default:       is_draw = 1'b0;
    endcase
  end

  assign lfsr_nx   = lfsr_step(lfsr_q);
  assign draw_prod = {{DrawW{1'b0}}, lfsr_nx} * {16'd0, draw_n};
  assign draw      = draw_prod[DrawW+15:16];

  // Cooling bound (cooling*10)/N + 2: reciprocal estimate, one correction
  assign cool_x = 12'(cooling_q) * 12'(COOL_MULT);
  assign quot0  = prod_q[27:16];
  assign rem0   = cool_x - 12'(quot0 * 12'(PixelCount));
  assign quot   = (rem0 >= 12'(PixelCount)) ? quot0 + 12'd1 : quot0;

  // Drift: (h[k-1] + 2*h[k-2]) / 3 through 683/2048
  assign drift_sum  = {2'b00, hist1_q} + {1'b0, hist2_q, 1'b0};
  assign drift_prod = {10'd0, drift_sum} * {10'd0, DIV3_MUL};

  assign head       = heat_q[0];
  assign spark_heat = (spark_q && (cnt == zone_y_q)) ? head + add_q : head;

  always_comb begin
    head_new = head;
    unique case (ctrl.op)
      OP_COOL:  head_new = (draw > DrawW'(head)) ? 8'd0 : head - 8'(draw);
      OP_DRIFT: head_new = (cnt < CntW'(2)) ? head : 8'(drift_prod >> DIV3_SHIFT);
      OP_EMIT:  head_new = spark_heat;
      default:  head_new = head;
    endcase
  end

  assign rotate = ctrl.adv && ((ctrl.op == OP_COOL) || (ctrl.op == OP_DRIFT) ||
                               (ctrl.op == OP_EMIT));
  assign emit   = ctrl.adv && (ctrl.op == OP_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooling_q  <= COOLING_RST;
      sparking_q <= SPARKING_RST;
      lfsr_q     <= SEED_RST;
      spark_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < PixelCount; i++) begin
        heat_q[i] <= 8'd0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_COOLING:  cooling_q  <= cfg_data_i[7:0];
          REG_SPARKING: sparking_q <= cfg_data_i[7:0];
          REG_SEED:     lfsr_q     <= (cfg_data_i != 16'd0) ? cfg_data_i : 16'd1;
          default: ;
        endcase
      end else if (is_draw && ctrl.adv) begin
        lfsr_q <= lfsr_nx;
      end

      if (frame_start) begin
        spark_q <= 1'b0;
      end else if (ctrl.op == OP_DRAW_ADD) begin
        spark_q <= 1'b1;
      end

      if (rotate) begin
        for (int i = 0; i < PixelCount - 1; i++) begin
          heat_q[i] <= heat_q[i+1];
        end
        heat_q[PixelCount-1] <= head_new;
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath payload, no reset
  always_ff @(posedge clk_i) begin
    unique case (ctrl.op)
      OP_BOUND_A:    prod_q   <= 28'(cool_x) * 28'(Recip);
      OP_BOUND_B:    bound_q  <= BoundW'(quot + 12'd2);
      OP_DRAW_SPARK: rnd_q    <= 8'(draw);
      OP_DRAW_ZONE:  zone_y_q <= CntW'(draw);
      OP_DRAW_ADD:   add_q    <= SPARK_BASE + 8'(draw);
      default: ;
    endcase
    if (ctrl.op == OP_DRIFT) begin
      hist1_q <= head;
      hist2_q <= hist1_q;
    end
    if (emit) begin
      out_pix_q  <= 5'(cnt);
      out_bgr_q  <= heat_palette(spark_heat);
      out_last_q <= (cnt == CntW'(PixelCount - 1));
    end
  end

  assign s_axis_tready_o = (ctrl.op == OP_WAIT);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_bgr_q, out_pix_q};
  assign m_axis_tlast_o  = out_last_q;

  `LFE_ASSERT_ALW(a_lfsr_nonzero, clk_i, rst_ni, lfsr_q != 16'd0)
  `LFE_ASSERT_NXT(a_bound_min, clk_i, rst_ni, ctrl.op == OP_BOUND_B, bound_q >= BoundW'(2))
  `LFE_ASSERT_IMP(a_emit_into_free_slot, clk_i, rst_ni, emit, !out_valid_q || m_axis_tready_i)
  `LFE_ASSERT_NXT(a_last_pixel_flag, clk_i, rst_ni, emit && (cnt == CntW'(PixelCount - 1)), m_axis_tvalid_o && m_axis_tlast_o)

endmodule

/* dv/tb_led_fire_effect_frame_unit.sv */
// Self-checking testbench for led_fire_effect_frame_unit: streams tick items in,
// predicts every pixel color of each frame, and checks the output stream.
// Depends on lfe_pkg and the unit's RTL only.
module tb_led_fire_effect_frame_unit;
  import lfe_pkg::*;

  localparam int                   STRIP_LEN    = 25;
  localparam int                   IGNITE_ZONE  = 7;
  localparam logic [15:0]          NOISE_TAPS   = 16'hB400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
  localparam int                   FRAME_CYCLES = 3 * STRIP_LEN + 7;
  localparam int                   SETTLE       = 2 * FRAME_CYCLES;
  localparam int                   LONG_HOLD    = 400;
  localparam int                   QUIET_LIMIT  = 4000;

  typedef struct packed {
    logic       last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [4:0] idx;
  } pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  led_fire_effect_frame_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // flame state as the unit should hold it
  logic [7:0]  cool_reg  = 8'd55;
  logic [7:0]  spark_reg = 8'd120;
  logic [7:0]  heat_q [STRIP_LEN];
  logic [15:0] noise_q = 16'd1;

  logic   tick_q [$];
  pixel_t pixel_q [$];

  int errors = 0;
  int items_taken = 0;
  int frames_taken = 0;
  int pixels_checked = 0;
  int reg_writes = 0;

  function automatic int unsigned noise_below(int unsigned n);
    logic [15:0] r;
    r = noise_q >> 1;
    if (noise_q[0]) r = r ^ NOISE_TAPS;
    noise_q = r;
    return int'((longint'(noise_q) * longint'(n)) >> 16);
  endfunction

  function automatic void advance_flame();
    int unsigned bound, c, y, a, t192, ramp;
    pixel_t px;
    bound = (int'(cool_reg) * 10) / STRIP_LEN + 2;
    for (int i = 0; i < STRIP_LEN; i++) begin
      c = noise_below(bound);
      heat_q[i] = (c > heat_q[i]) ? 8'd0 : heat_q[i] - c[7:0];
    end
    // old values feed the cell above, so walk top down
    for (int k = STRIP_LEN - 1; k >= 2; k--)
      heat_q[k] = 8'((int'(heat_q[k-1]) + 2 * int'(heat_q[k-2])) / 3);
    if (noise_below(255) < spark_reg) begin
      y = noise_below(IGNITE_ZONE);
      a = 160 + noise_below(95);
      heat_q[y] = heat_q[y] + a[7:0];
    end
    for (int i = 0; i < STRIP_LEN; i++) begin
      t192 = (int'(heat_q[i]) * 191 + 127) / 255;
      ramp = (t192 & 32'h3F) << 2;
      px.idx  = 5'(i);
      px.last = (i == STRIP_LEN - 1);
      if (t192 > 32'h80) begin
        px.red = 8'hFF; px.green = 8'hFF; px.blue = ramp[7:0];
      end else if (t192 > 32'h40) begin
        px.red = 8'hFF; px.green = ramp[7:0]; px.blue = 8'h00;
      end else begin
        px.red = ramp[7:0]; px.green = 8'h00; px.blue = 8'h00;
      end
      pixel_q.push_back(px);
    end
  endfunction

  // sender: bursts of items separated by random gaps
  int burst_left = 4;
  int gap_left = 0;

  always @(posedge clk_i) begin
    logic taken;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      taken = s_tvalid && s_tready;
      if (taken) begin
        items_taken++;
        if (s_tdata[0]) begin
          frames_taken++;
          advance_flame();
        end
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 100);
        end else begin
          burst_left--;
        end
      end
      if (taken || !s_tvalid) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {7'd0, tick_q.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern steps through four modes on a free-running counter; one long hold on request
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_cnt = 0;
  logic [9:0]  rx_cnt = '0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      rx_cnt <= rx_cnt + 10'd1;
      if (hold_req && !hold_done) begin
        hold_cnt <= hold_cnt + 1;
        if (hold_cnt == LONG_HOLD) hold_done <= 1'b1;
        m_tready <= 1'b0;
      end else begin
        case (rx_cnt[9:8])
          2'd0:    m_tready <= 1'b1;
          2'd1:    m_tready <= 1'($urandom_range(0, 1));
          2'd2:    m_tready <= (rx_cnt[2:0] == 3'd0);
          default: m_tready <= (rx_cnt[4:3] != 2'd0);
        endcase
      end
    end
  end

  // output checker
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = {m_tlast, m_tdata[28:0]};
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, actual idx=%0d rgb=%h%h%h last=%b",
                 $time, got.idx, got.red, got.green, got.blue, got.last);
      end else begin
        want = pixel_q.pop_front();
        pixels_checked++;
        if (got !== want) begin
          errors++;
          if (errors <= 30)
            $display("%0t: pixel mismatch, expected idx=%0d rgb=%h%h%h last=%b, actual idx=%0d rgb=%h%h%h last=%b",
                     $time, want.idx, want.red, want.green, want.blue, want.last,
                     got.idx, got.red, got.green, got.blue, got.last);
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  int quiet = 0;

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      REG_COOLING:  cool_reg = value[7:0];
      REG_SPARKING: spark_reg = value[7:0];
      REG_SEED:     noise_q = (value == 16'd0) ? 16'd1 : value;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (tick_q.size() != 0 || s_tvalid || pixel_q.size() != 0) @(posedge clk_i);
    // a trailing tick-clear item may still be in flight
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic queue_ticks(int count, int idle_pct);
    for (int i = 0; i < count; i++)
      tick_q.push_back($urandom_range(0, 99) >= idle_pct);
  endtask

  initial begin
    logic [7:0] cool_v, spark_v;
    for (int i = 0; i < STRIP_LEN; i++) heat_q[i] = 8'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, with tick-clear items around real frames
    tick_q.push_back(1'b0);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b1);
    tick_q.push_back(1'b0);
    wait_idle();

    // no cooling, always spark, zero seed: bottom cells wrap past 255
    write_reg(REG_COOLING, 16'd0);
    write_reg(REG_SPARKING, 16'd255);
    write_reg(REG_SEED, 16'd0);
    queue_ticks(8, 0);
    wait_idle();

    // maximum cooling, never spark, top seed; unknown index must be ignored
    write_reg(REG_COOLING, 16'd255);
    write_reg(REG_SPARKING, 16'd0);
    write_reg(REG_SEED, 16'hFFFF);
    write_reg(REG_UNUSED, 16'hFFFF);
    queue_ticks(4, 0);
    wait_idle();

    // back to defaults; output held off long while frames keep arriving
    write_reg(REG_COOLING, 16'd55);
    write_reg(REG_SPARKING, 16'd120);
    write_reg(REG_SEED, 16'hACE1);
    @(posedge clk_i);
    hold_req <= 1'b1;
    queue_ticks(50, 0);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      cool_v  = (ph == 0) ? 8'd255 : 8'($urandom_range(0, 255));
      spark_v = (ph == 1) ? 8'd0 : (ph == 2) ? 8'd255 : 8'($urandom_range(0, 255));
      // upper byte is don't-care for the 8-bit registers
      write_reg(REG_COOLING, {8'($urandom_range(0, 255)), cool_v});
      write_reg(REG_SPARKING, {8'($urandom_range(0, 255)), spark_v});
      if ($urandom_range(0, 1) == 1)
        write_reg(REG_SEED, 16'($urandom_range(0, 65535)));
      if (ph == 3) write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
      queue_ticks(48, 15);
      wait_idle();
    end

    $display("Ran %0d input items (%0d frames) over %0d register writes,",
             items_taken, frames_taken, reg_writes);
    $display("checked %0d pixels with %0d errors.", pixels_checked, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/lfe_pkg.sv
hdl/lfe_useq.sv
hdl/led_fire_effect_frame_unit.sv
dv/tb_led_fire_effect_frame_unit.sv
